// ===== src/icymd_pkg.sv =====
// icymd_pkg: shared constants and codes for the stream metadata deframer
// no dependencies; imported by icy_metadata_deframer_core
`default_nettype none

package icymd_pkg;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int OFFSET_W   = 12;
   localparam int INTERVAL_W = 20;

   // metadata store geometry
   localparam int META_STORE_BYTES = 4096;
   localparam int FILL_W           = $clog2(META_STORE_BYTES + 1);
   // body length unit is 16 bytes, so the length byte is shifted by this much
   localparam int META_UNIT_SHIFT  = 4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_AUDIO   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LENGTH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BODY    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

   // front-end phase
   localparam logic PHASE_AUDIO = 1'b0;
   localparam logic PHASE_BODY  = 1'b1;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [KIND_W-1:0]     kind_type;
   typedef logic [OFFSET_W-1:0]   offset_type;
   typedef logic [INTERVAL_W-1:0] interval_type;

endpackage

`default_nettype wire

// ===== src/icy_metadata_deframer_core.sv =====
// An accepted word passes stage one, then the result register, to rsp_.
// One word per clock unless stalled; the limit is store read-compare-write,
// read at accept and written one stage later, so addresses never collide.
// Reset (synchronous, active high) clears control state and the interval;
// the store is not swept: a fill count marks written entries, others read 0.
// A restart word clears the counters, the phase and the fill count in order.
`default_nettype none

module icy_metadata_deframer_core (
   input  wire                       clock,
   input  wire                       reset,
   // configuration
   input  wire                       csr_wr_en,
   input  wire icymd_pkg::interval_type csr_wr_data,
   // input words
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire icymd_pkg::byte_type  req_in_byte,
   input  wire                       req_restart,
   // result words
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output icymd_pkg::byte_type       rsp_out_byte,
   output icymd_pkg::kind_type       rsp_byte_kind,
   output icymd_pkg::offset_type     rsp_meta_offset,
   output logic                      rsp_block_end,
   output logic                      rsp_metadata_changed
);
   import icymd_pkg::*;

   // configuration register
   interval_type interval_ff;

   // front-end state
   logic         phase_ff,  phase_in;
   interval_type count_ff,  count_in;
   offset_type   remain_ff, remain_in;
   offset_type   index_ff,  index_in;

   // stage one
   logic         s1_valid_ff;
   byte_type     s1_byte_ff,  s1_byte_in;
   kind_type     s1_kind_ff,  s1_kind_in;
   offset_type   s1_off_ff,   s1_off_in;
   logic         s1_end_ff,   s1_end_in;
   byte_type     rd_data_ff;

   // back-end state
   logic [FILL_W-1:0] fill_ff;
   logic              diff_ff;
   byte_type          store_mem [META_STORE_BYTES];

   // handshake
   logic accept;
   logic advance;
   logic s1_move;

   // compare stage
   byte_type          old_byte;
   logic              diff_next;
   logic [FILL_W-1:0] off_plus;
   logic              store_hit;
   logic              chg_in;

   assign advance   = !rsp_valid || !rsp_stall;
   assign s1_move   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   // front end: classify the word and step the counters
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      index_in   = index_ff;
      s1_byte_in = req_in_byte;
      s1_kind_in = KIND_AUDIO;
      s1_off_in  = '0;
      s1_end_in  = 1'b0;
      if (req_restart) begin
         phase_in   = PHASE_AUDIO;
         count_in   = '0;
         remain_in  = '0;
         index_in   = '0;
         s1_byte_in = '0;
         s1_kind_in = KIND_RESTART;
      end else if (phase_ff == PHASE_BODY) begin
         s1_kind_in = KIND_BODY;
         s1_off_in  = index_ff;
         index_in   = index_ff + offset_type'(1);
         remain_in  = remain_ff - offset_type'(1);
         if (remain_in == '0) begin
            s1_end_in = 1'b1;
            phase_in  = PHASE_AUDIO;
            count_in  = '0;
            index_in  = '0;
         end
      end else if (interval_ff == '0) begin
         s1_kind_in = KIND_AUDIO;
      end else if (count_ff >= interval_ff) begin
         s1_kind_in = KIND_LENGTH;
         count_in   = '0;
         index_in   = '0;
         remain_in  = offset_type'({req_in_byte, {META_UNIT_SHIFT{1'b0}}});
         if (remain_in == '0) begin
            s1_end_in = 1'b1;
         end else begin
            phase_in = PHASE_BODY;
         end
      end else begin
         count_in = count_ff + interval_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_AUDIO;
         count_ff    <= '0;
         remain_ff   <= '0;
         index_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            remain_ff <= remain_in;
            index_ff  <= index_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= s1_byte_in;
         s1_kind_ff <= s1_kind_in;
         s1_off_ff  <= s1_off_in;
         s1_end_ff  <= s1_end_in;
      end
   end

   // store read at accept, write when the body word leaves stage one
   always_ff @(posedge clock) begin
      if (accept && !req_restart && phase_ff == PHASE_BODY) begin
         rd_data_ff <= store_mem[index_ff];
      end
      if (s1_move && s1_kind_ff == KIND_BODY &&
          {1'b0, s1_off_ff} < FILL_W'(META_STORE_BYTES)) begin
         store_mem[s1_off_ff] <= s1_byte_ff;
      end
   end

   // compare against the previous block; unwritten entries read as zero
   always_comb begin
      off_plus  = FILL_W'(s1_off_ff) + FILL_W'(1);
      store_hit = FILL_W'(s1_off_ff) < fill_ff;
      old_byte  = store_hit ? rd_data_ff : '0;
      diff_next = diff_ff || (old_byte != s1_byte_ff);
      chg_in    = (s1_kind_ff == KIND_BODY) && s1_end_ff && diff_next;
   end

   // fill count and change tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         diff_ff <= 1'b0;
      end else if (s1_move) begin
         case (s1_kind_ff)
            KIND_RESTART: begin
               fill_ff <= '0;
               diff_ff <= 1'b0;
            end
            KIND_LENGTH: begin
               diff_ff <= 1'b0;
            end
            KIND_BODY: begin
               if (off_plus > fill_ff) begin
                  fill_ff <= off_plus;
               end
               diff_ff <= s1_end_ff ? 1'b0 : diff_next;
            end
            default: begin
               diff_ff <= diff_ff;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (advance) begin
         rsp_valid <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_out_byte         <= s1_byte_ff;
         rsp_byte_kind        <= s1_kind_ff;
         rsp_meta_offset      <= s1_off_ff;
         rsp_block_end        <= s1_end_ff;
         rsp_metadata_changed <= chg_in;
      end
   end

   // checks
   a_chg_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_metadata_changed |-> rsp_block_end)
      else $error("metadata_changed without block_end");

   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |->
         (rsp_byte_kind == KIND_BODY || rsp_byte_kind == KIND_LENGTH))
      else $error("block_end on a word that is neither body nor length");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_kind != KIND_BODY |-> rsp_meta_offset == '0)
      else $error("nonzero offset outside a metadata body");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(META_STORE_BYTES))
      else $error("fill count beyond store size");

endmodule

`default_nettype wire
